// ===== sv/ddl_pkg.sv =====
package ddl_pkg;

   localparam int unsigned KEPT_LIMIT_DEF = 1024;

   localparam int unsigned DIM_W      = 15;
   localparam int unsigned FIT_NUM_W  = 2 * DIM_W;
   localparam int unsigned BOX_NUM_W  = 62;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 17;

   // Queue depth between front and back; must be a power of two.
   localparam int unsigned QDEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NETWORK_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NETWORK_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELATIVE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES    = 3'd6;

   localparam logic [1:0] KIND_BOX   = 2'd0;
   localparam logic [1:0] KIND_PROB  = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_COORD = 2'd1,
      OP_BOX   = 2'd2,
      OP_CLASS = 2'd3
   } ddl_op_code_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               frame_last;
   } ddl_req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         det_index;
      logic [7:0]         class_index;
      logic signed [31:0] box_x;
      logic signed [31:0] box_y;
      logic signed [31:0] box_w;
      logic signed [31:0] box_h;
      logic signed [31:0] objectness;
      logic signed [31:0] probability;
      logic [10:0]        det_count;
      logic               last;
   } ddl_rsp_type;

   typedef struct packed {
      logic [16:0]      threshold;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [DIM_W-1:0] network_width;
      logic [DIM_W-1:0] network_height;
      logic             relative_coords;
      logic [7:0]       num_classes;
   } ddl_cfg_type;

   typedef struct packed {
      ddl_op_code_type    op;
      logic [1:0]         coord_idx;
      logic signed [31:0] value;
      logic               frame_last;
      logic [9:0]         det_index;
      logic [7:0]         class_index;
      logic [10:0]        count;
   } ddl_op_type;

   function automatic logic [DIM_W-1:0] nz15(input logic [DIM_W-1:0] v);
      return (v == '0) ? DIM_W'(1) : v;
   endfunction

endpackage

// ===== sv/ddl_div.sv =====
module ddl_div #(
   parameter int unsigned NumW = 30,
   parameter int unsigned DenW = 15
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic            done,
   output logic [NumW-1:0] quot,
   output logic [DenW-1:0] rem
);
   localparam int unsigned CntW = $clog2(NumW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumW-1:0] num_ff, num_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [DenW:0]   trial;
   logic [DenW:0]   diff;
   logic            ge;

   // Restoring division, one quotient bit per cycle; quotient bits shift into num_ff.
   always_comb begin
      trial   = {rem_ff, num_ff[NumW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(NumW);
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], ge};
         rem_in = ge ? diff[DenW-1:0] : trial[DenW-1:0];
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;
endmodule

// ===== sv/ddl_fit.sv =====
module ddl_fit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  ddl_pkg::ddl_cfg_type           cfg,
   output logic                           busy,
   output logic [ddl_pkg::DIM_W-1:0]      fit_w,
   output logic [ddl_pkg::DIM_W-1:0]      fit_h
);
   import ddl_pkg::*;

   typedef enum logic [3:0] {
      FS_IDLE = 4'b0001,
      FS_MUL  = 4'b0010,
      FS_CMP  = 4'b0100,
      FS_DIV  = 4'b1000
   } fit_state_type;

   fit_state_type        state_ff, state_in;
   logic [FIT_NUM_W-1:0] pa_ff, pa_in;
   logic [FIT_NUM_W-1:0] pb_ff, pb_in;
   logic                 less_ff, less_in;
   logic [DIM_W-1:0]     fw_ff, fw_in;
   logic [DIM_W-1:0]     fh_ff, fh_in;
   logic [DIM_W-1:0]     iw, ih, nw, nh;
   logic                 div_start;
   logic [FIT_NUM_W-1:0] div_num;
   logic [DIM_W-1:0]     div_den;
   logic                 div_done;
   logic [FIT_NUM_W-1:0] div_quot;

   always_comb begin
      iw        = nz15(cfg.image_width);
      ih        = nz15(cfg.image_height);
      nw        = nz15(cfg.network_width);
      nh        = nz15(cfg.network_height);
      state_in  = state_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      less_in   = less_ff;
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      div_start = 1'b0;
      div_num   = less_in ? pa_ff : pb_ff;
      div_den   = less_in ? iw : ih;
      unique case (state_ff)
         FS_IDLE: begin
         end
         FS_MUL: begin
            pa_in    = FIT_NUM_W'(nw) * FIT_NUM_W'(ih);
            pb_in    = FIT_NUM_W'(nh) * FIT_NUM_W'(iw);
            state_in = FS_CMP;
         end
         FS_CMP: begin
            less_in   = pa_ff < pb_ff;
            div_start = 1'b1;
            div_num   = less_in ? pa_ff : pb_ff;
            div_den   = less_in ? iw : ih;
            if (less_in) begin
               fw_in = nw;
            end else begin
               fh_in = nh;
            end
            state_in = FS_DIV;
         end
         FS_DIV: begin
            if (div_done) begin
               if (less_ff) begin
                  fh_in = nz15(div_quot[DIM_W-1:0]);
               end else begin
                  fw_in = nz15(div_quot[DIM_W-1:0]);
               end
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
      if (start) begin
         state_in = FS_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      less_ff <= less_in;
      fw_ff   <= fw_in;
      fh_ff   <= fh_in;
   end

   ddl_div #(
      .NumW(FIT_NUM_W),
      .DenW(DIM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   ()
   );

   assign busy  = state_ff != FS_IDLE;
   assign fit_w = fw_ff;
   assign fit_h = fh_ff;
endmodule

// ===== sv/ddl_front.sv =====
module ddl_front #(
   parameter int unsigned MaxBoxes = ddl_pkg::KEPT_LIMIT_DEF,
   parameter int unsigned CntW     = $clog2(MaxBoxes + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ddl_pkg::ddl_cfg_type cfg,
   input  logic                 fit_busy,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ddl_pkg::ddl_req_type req_data,
   output logic                 q_valid,
   input  logic                 q_pop,
   output ddl_pkg::ddl_op_type  q_data
);
   import ddl_pkg::*;

   localparam int unsigned PtrW  = $clog2(QDEPTH);
   localparam int unsigned FillW = $clog2(QDEPTH + 1);

   logic [8:0]       pos_ff, pos_in;
   logic             keep_ff, keep_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;
   ddl_op_type       q_mem_ff [QDEPTH];
   ddl_op_type       op;
   logic             accept;
   logic             push;
   logic             above;
   logic             keep_new;
   logic [CntW-1:0]  cnt_after;

   always_comb begin
      accept    = req_valid && !req_stall;
      above     = $signed({req_data.value[31], req_data.value}) >
                  $signed({16'b0, cfg.threshold});
      keep_new  = above && (cnt_ff < CntW'(MaxBoxes));
      cnt_after = cnt_ff;
      pos_in    = pos_ff;
      keep_in   = keep_ff;

      op.op          = OP_NONE;
      op.coord_idx   = pos_ff[1:0];
      op.value       = req_data.value;
      op.frame_last  = req_data.frame_last;
      op.det_index   = 10'(cnt_ff);
      op.class_index = 8'(pos_ff - 9'd5);

      if (pos_ff < 9'd4) begin
         op.op = OP_COORD;
      end else if (pos_ff == 9'd4) begin
         keep_in = keep_new;
         if (keep_new) begin
            op.op     = OP_BOX;
            cnt_after = cnt_ff + CntW'(1);
         end
      end else if (keep_ff) begin
         op.op        = OP_CLASS;
         op.det_index = 10'(cnt_ff - CntW'(1));
      end
      op.count = 11'(cnt_after);

      // An entry closes once its position reaches the last class word.
      if (pos_ff >= 9'd4 + {1'b0, cfg.num_classes}) begin
         pos_in  = '0;
         keep_in = 1'b0;
      end else begin
         pos_in = pos_ff + 9'd1;
      end
      cnt_in = cnt_after;
      if (req_data.frame_last) begin
         pos_in  = '0;
         keep_in = 1'b0;
         cnt_in  = '0;
      end

      push      = accept && ((op.op != OP_NONE) || req_data.frame_last);
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FillW'(push) - FillW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         keep_ff   <= 1'b0;
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            keep_ff <= keep_in;
            cnt_ff  <= cnt_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= op;
      end
   end

   assign req_stall = (fill_ff == FillW'(QDEPTH)) || fit_busy;
   assign q_valid   = fill_ff != '0;
   assign q_data    = q_mem_ff[rd_ptr_ff];
endmodule

// ===== sv/ddl_back.sv =====
module ddl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ddl_pkg::ddl_cfg_type      cfg,
   input  logic [ddl_pkg::DIM_W-1:0] fit_w,
   input  logic [ddl_pkg::DIM_W-1:0] fit_h,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  ddl_pkg::ddl_op_type       q_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ddl_pkg::ddl_rsp_type      rsp_data
);
   import ddl_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'h0001,
      S_BMUL  = 14'h0002,
      S_BOFF  = 14'h0004,
      S_BABS  = 14'h0008,
      S_BSCL0 = 14'h0010,
      S_BSCL1 = 14'h0020,
      S_BSCL2 = 14'h0040,
      S_BDIV  = 14'h0080,
      S_BRND  = 14'h0100,
      S_BSAT  = 14'h0200,
      S_BEMIT = 14'h0400,
      S_PMUL  = 14'h0800,
      S_PEMIT = 14'h1000,
      S_COUNT = 14'h2000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ddl_rsp_type        rsp_ff, rsp_in;
   ddl_op_type         ent_ff, ent_in;
   logic [1:0]         k_ff, k_in;
   logic signed [31:0] coord_ff [4];
   logic signed [31:0] box_ff [4];
   logic signed [31:0] obj_ff, obj_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [47:0] n_ff, n_in;
   logic               neg_ff, neg_in;
   logic [46:0]        mag_ff, mag_in;
   logic [38:0]        lo_ff, lo_in;
   logic [37:0]        hi_ff, hi_in;
   logic [BOX_NUM_W-1:0] qa_ff, qa_in;
   logic signed [63:0] p_ff, p_in;
   logic               coord_we;
   logic               box_we;
   logic signed [31:0] box_res;
   logic [DIM_W-1:0]   net_sel, fit_sel, img_sel, scale, off_diff;
   logic [47:0]        off;
   logic signed [47:0] p48;
   logic signed [31:0] prob;
   logic               out_free;
   logic               div_start;
   logic [BOX_NUM_W-1:0] div_num;
   logic               div_done;
   logic [BOX_NUM_W-1:0] div_quot;
   logic [DIM_W-1:0]   div_rem;

   always_comb begin
      // Odd coordinate slots (y, h) use the height chain.
      net_sel  = k_ff[0] ? nz15(cfg.network_height) : nz15(cfg.network_width);
      fit_sel  = k_ff[0] ? fit_h : fit_w;
      img_sel  = k_ff[0] ? nz15(cfg.image_height) : nz15(cfg.image_width);
      scale    = cfg.relative_coords ? DIM_W'(1) : img_sel;
      off_diff = net_sel - fit_sel;
      off      = k_ff[1] ? 48'd0 : {18'd0, off_diff, 15'd0};
      div_num  = BOX_NUM_W'({hi_ff, 24'd0}) + BOX_NUM_W'(lo_ff);

      if (!neg_ff) begin
         box_res = (qa_ff > BOX_NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                      : $signed(qa_ff[31:0]);
      end else begin
         box_res = (qa_ff > BOX_NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                      : $signed(~qa_ff[31:0] + 32'd1);
      end

      p48 = p_ff[63:16];
      if (p48 > $signed({31'd0, cfg.threshold})) begin
         prob = (p48 > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : p48[31:0];
      end else begin
         prob = '0;
      end

      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ent_in       = ent_ff;
      k_in         = k_ff;
      obj_in       = obj_ff;
      prod_in      = prod_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      qa_in        = qa_ff;
      p_in         = p_ff;
      q_pop        = 1'b0;
      coord_we     = 1'b0;
      box_we       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ent_in = q_data;
               k_in   = '0;
               case (q_data.op)
                  OP_COORD: begin
                     coord_we = 1'b1;
                     state_in = q_data.frame_last ? S_COUNT : S_IDLE;
                  end
                  OP_BOX: begin
                     obj_in   = q_data.value;
                     state_in = S_BMUL;
                  end
                  OP_CLASS: state_in = S_PMUL;
                  default:  state_in = S_COUNT;
               endcase
            end
         end
         S_BMUL: begin
            prod_in  = coord_ff[k_ff] * $signed({1'b0, net_sel});
            state_in = S_BOFF;
         end
         S_BOFF: begin
            n_in     = prod_ff - $signed(off);
            state_in = S_BABS;
         end
         S_BABS: begin
            neg_in   = n_ff[47];
            mag_in   = n_ff[47] ? 47'(-n_ff) : 47'(n_ff);
            state_in = S_BSCL0;
         end
         S_BSCL0: begin
            lo_in    = mag_ff[23:0] * scale;
            state_in = S_BSCL1;
         end
         S_BSCL1: begin
            hi_in    = mag_ff[46:24] * scale;
            state_in = S_BSCL2;
         end
         S_BSCL2: begin
            div_start = 1'b1;
            state_in  = S_BDIV;
         end
         S_BDIV: begin
            if (div_done) begin
               state_in = S_BRND;
            end
         end
         S_BRND: begin
            // Floor of a negative quotient steps one further from zero.
            qa_in    = div_quot + BOX_NUM_W'(neg_ff && (div_rem != '0));
            state_in = S_BSAT;
         end
         S_BSAT: begin
            box_we = 1'b1;
            if (k_ff == 2'd3) begin
               state_in = S_BEMIT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_BMUL;
            end
         end
         S_BEMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.kind        = KIND_BOX;
               rsp_in.det_index   = ent_ff.det_index;
               rsp_in.box_x       = box_ff[0];
               rsp_in.box_y       = box_ff[1];
               rsp_in.box_w       = box_ff[2];
               rsp_in.box_h       = box_ff[3];
               rsp_in.objectness  = obj_ff;
               rsp_in.last        = !ent_ff.frame_last;
               state_in           = ent_ff.frame_last ? S_COUNT : S_IDLE;
            end
         end
         S_PMUL: begin
            p_in     = obj_ff * ent_ff.value;
            state_in = S_PEMIT;
         end
         S_PEMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.kind        = KIND_PROB;
               rsp_in.det_index   = ent_ff.det_index;
               rsp_in.class_index = ent_ff.class_index;
               rsp_in.probability = prob;
               rsp_in.last        = !ent_ff.frame_last;
               state_in           = ent_ff.frame_last ? S_COUNT : S_IDLE;
            end
         end
         S_COUNT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.kind      = KIND_COUNT;
               rsp_in.det_count = ent_ff.count;
               rsp_in.last      = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      ent_ff  <= ent_in;
      k_ff    <= k_in;
      obj_ff  <= obj_in;
      prod_ff <= prod_in;
      n_ff    <= n_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      qa_ff   <= qa_in;
      p_ff    <= p_in;
      if (coord_we) begin
         coord_ff[q_data.coord_idx] <= q_data.value;
      end
      if (box_we) begin
         box_ff[k_ff] <= box_res;
      end
   end

   ddl_div #(
      .NumW(BOX_NUM_W),
      .DenW(DIM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (fit_sel),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== sv/detection_decode_letterbox_top.sv =====
// Detection decoder with letterbox correction.
// The req channel carries one Q16.16 prediction word per item; entries are
// x, y, w, h, objectness and one score per class, and frame_last marks the
// final word of a frame. The rsp channel returns box results, per-class
// probability results and a detection count at frame end; last is set on the
// final result caused by an input word. The csr port writes the registers.
// The front accepts one word per cycle while req_stall is low, into a
// two-entry queue. The back end takes one entry at a time: it stores a
// coordinate word, multiplies a class word by the objectness and emits it,
// and runs each coordinate of a kept box through multiply, offset, magnitude,
// scaling, a 62-step serial divider, rounding and saturation before emitting
// the box. After reset and after every register write, the fitted size is
// recomputed by a 30-step serial divider while req_stall stays high. When
// rsp_stall is high the held result waits in the output register, the back
// end pauses and the queue fills, after which req_stall rises.
module detection_decode_letterbox_top #(
   parameter int unsigned KEPT_LIMIT = ddl_pkg::KEPT_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ddl_pkg::ddl_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ddl_pkg::ddl_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [ddl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ddl_pkg::*;

   localparam int unsigned CntW = $clog2(KEPT_LIMIT + 1);

   ddl_cfg_type      cfg_ff, cfg_in;
   logic             fit_busy;
   logic [DIM_W-1:0] fit_w, fit_h;
   logic             q_valid, q_pop;
   ddl_op_type       q_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:      cfg_in.threshold       = csr_wdata;
            CSR_IMAGE_WIDTH:    cfg_in.image_width     = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   cfg_in.image_height    = csr_wdata[DIM_W-1:0];
            CSR_NETWORK_WIDTH:  cfg_in.network_width   = csr_wdata[DIM_W-1:0];
            CSR_NETWORK_HEIGHT: cfg_in.network_height  = csr_wdata[DIM_W-1:0];
            CSR_RELATIVE:       cfg_in.relative_coords = csr_wdata[0];
            CSR_NUM_CLASSES:    cfg_in.num_classes     = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold       <= 17'd16384;
         cfg_ff.image_width     <= DIM_W'(416);
         cfg_ff.image_height    <= DIM_W'(416);
         cfg_ff.network_width   <= DIM_W'(416);
         cfg_ff.network_height  <= DIM_W'(416);
         cfg_ff.relative_coords <= 1'b1;
         cfg_ff.num_classes     <= 8'd80;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ddl_fit u_fit (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .cfg   (cfg_ff),
      .busy  (fit_busy),
      .fit_w (fit_w),
      .fit_h (fit_h)
   );

   ddl_front #(
      .MaxBoxes(KEPT_LIMIT),
      .CntW    (CntW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fit_busy  (fit_busy),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data)
   );

   ddl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fit_w     (fit_w),
      .fit_h     (fit_h),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_fit_stalls: assert property (@(posedge clock) disable iff (reset)
      fit_busy |-> req_stall)
      else $error("input accepted while the fitted size is being recomputed");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   a_count_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_COUNT)) |-> rsp_data.last)
      else $error("count result not marked as last");

   a_refit_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> fit_busy)
      else $error("fitted size not recomputed after reset");
endmodule

// ===== tb/detection_decode_letterbox_top_test.sv =====
module detection_decode_letterbox_top_test;
   import ddl_pkg::*;

   localparam int unsigned RUN_LIMIT = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned BOX_LIMIT = KEPT_LIMIT_DEF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   ddl_req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   ddl_rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   detection_decode_letterbox_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Register mirror and decoder state of the predictor.
   logic [16:0] thr_q;
   logic [14:0] img_w_q, img_h_q, net_w_q, net_h_q;
   logic rel_q;
   logic [7:0] classes_q;
   longint fit_w, fit_h;
   int unsigned word_pos;
   logic [31:0] coord_hold [4];
   logic signed [31:0] obj_hold;
   logic box_kept;
   int unsigned kept_count;

   ddl_req_type pending_words[$];
   ddl_rsp_type expected_results[$];
   int idle_pct;
   int unsigned words_sent;
   int unsigned results_seen;
   int unsigned boxes_seen;
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned hold_count;
   bit pressure_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint at_least_one(longint v);
      return (v == 0) ? 1 : v;
   endfunction

   task automatic refit_sizes();
      longint iw, ih, nw, nh;
      iw = at_least_one(img_w_q);
      ih = at_least_one(img_h_q);
      nw = at_least_one(net_w_q);
      nh = at_least_one(net_h_q);
      if (nw * ih < nh * iw) begin
         fit_w = nw;
         fit_h = (ih * nw) / iw;
      end else begin
         fit_h = nh;
         fit_w = (iw * nh) / ih;
      end
      fit_w = at_least_one(fit_w);
      fit_h = at_least_one(fit_h);
   endtask

   function automatic logic [31:0] letterbox_centre(logic [31:0] c, longint net, longint fit,
                                                    longint img);
      longint n, s;
      n = longint'($signed(c)) * net - (net - fit) * 32768;
      s = rel_q ? 1 : img;
      return clamp32(floor_quot(n * s, fit));
   endfunction

   function automatic logic [31:0] letterbox_extent(logic [31:0] c, longint net, longint fit,
                                                    longint img);
      longint s;
      s = rel_q ? 1 : img;
      return clamp32(floor_quot(longint'($signed(c)) * net * s, fit));
   endfunction

   // Works out the results of one accepted word and queues them.
   task automatic decode_word(ddl_req_type w);
      ddl_rsp_type r [2];
      int n;
      longint p;
      n = 0;
      r[0] = '0;
      r[1] = '0;
      if (word_pos < 4) begin
         coord_hold[word_pos] = w.value;
      end else if (word_pos == 4) begin
         obj_hold = w.value;
         box_kept = (longint'(w.value) > longint'(thr_q)) && (kept_count < BOX_LIMIT);
         if (box_kept) begin
            r[0].kind = KIND_BOX;
            r[0].det_index = kept_count[9:0];
            r[0].box_x = letterbox_centre(coord_hold[0], at_least_one(net_w_q), fit_w,
                                          at_least_one(img_w_q));
            r[0].box_y = letterbox_centre(coord_hold[1], at_least_one(net_h_q), fit_h,
                                          at_least_one(img_h_q));
            r[0].box_w = letterbox_extent(coord_hold[2], at_least_one(net_w_q), fit_w,
                                          at_least_one(img_w_q));
            r[0].box_h = letterbox_extent(coord_hold[3], at_least_one(net_h_q), fit_h,
                                          at_least_one(img_h_q));
            r[0].objectness = w.value;
            kept_count++;
            n = 1;
         end
      end else if (box_kept) begin
         p = floor_quot(longint'(obj_hold) * longint'(w.value), 65536);
         r[0].kind = KIND_PROB;
         r[0].det_index = 10'(kept_count - 1);
         r[0].class_index = 8'(word_pos - 5);
         r[0].probability = (p > longint'(thr_q)) ? clamp32(p) : '0;
         n = 1;
      end
      if (word_pos >= 4 + classes_q) begin
         word_pos = 0;
         box_kept = 1'b0;
      end else begin
         word_pos = (word_pos + 1) & 511;
      end
      if (w.frame_last) begin
         r[n].kind = KIND_COUNT;
         r[n].det_count = 11'(kept_count);
         n++;
         kept_count = 0;
         word_pos = 0;
         box_kept = 1'b0;
      end
      if (n > 0) r[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
   endtask

   // Sender: offers queued words, holding a stalled word unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_word(req_data);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d det %0d", rsp_data.kind,
                           rsp_data.det_index);
            end else begin
               ddl_rsp_type e;
               e = expected_results.pop_front();
               if (e.kind == KIND_BOX) boxes_seen++;
               if (rsp_data.kind !== e.kind || rsp_data.det_index !== e.det_index ||
                   rsp_data.class_index !== e.class_index || rsp_data.box_x !== e.box_x ||
                   rsp_data.box_y !== e.box_y || rsp_data.box_w !== e.box_w ||
                   rsp_data.box_h !== e.box_h || rsp_data.objectness !== e.objectness ||
                   rsp_data.probability !== e.probability ||
                   rsp_data.det_count !== e.det_count || rsp_data.last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch on result %0d", results_seen);
                     $display("  expected kind %0d det %0d cls %0d xywh %h %h %h %h obj %h",
                              e.kind, e.det_index, e.class_index, e.box_x, e.box_y,
                              e.box_w, e.box_h, e.objectness);
                     $display("           prob %h count %0d last %0b", e.probability,
                              e.det_count, e.last);
                     $display("  actual   kind %0d det %0d cls %0d xywh %h %h %h %h obj %h",
                              rsp_data.kind, rsp_data.det_index, rsp_data.class_index,
                              rsp_data.box_x, rsp_data.box_y, rsp_data.box_w,
                              rsp_data.box_h, rsp_data.objectness);
                     $display("           prob %h count %0d last %0b", rsp_data.probability,
                              rsp_data.det_count, rsp_data.last);
                  end
               end
            end
         end
         // One long hold-off partway through lets the block back up into its input.
         if (!pressure_done && words_sent >= 300) begin
            pressure_done <= 1'b1;
            hold_count <= 600;
            rsp_stall <= 1'b1;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_q = val[16:0];
         CSR_IMAGE_WIDTH: img_w_q = val[14:0];
         CSR_IMAGE_HEIGHT: img_h_q = val[14:0];
         CSR_NETWORK_WIDTH: net_w_q = val[14:0];
         CSR_NETWORK_HEIGHT: net_h_q = val[14:0];
         CSR_RELATIVE: rel_q = val[0];
         CSR_NUM_CLASSES: classes_q = val[7:0];
         default: ;
      endcase
      refit_sizes();
   endtask

   task automatic write_all(logic [16:0] th, logic [14:0] iw, logic [14:0] ih,
                            logic [14:0] nw, logic [14:0] nh, logic rel, logic [7:0] nc);
      write_reg(CSR_THRESHOLD, th);
      write_reg(CSR_IMAGE_WIDTH, iw);
      write_reg(CSR_IMAGE_HEIGHT, ih);
      write_reg(CSR_NETWORK_WIDTH, nw);
      write_reg(CSR_NETWORK_HEIGHT, nh);
      write_reg(CSR_RELATIVE, rel);
      write_reg(CSR_NUM_CLASSES, nc);
   endtask

   // Waits until every word is taken and every result is back, then lets any
   // queued coordinate words finish inside the block.
   task automatic settle();
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_word(logic [31:0] v, logic fl);
      ddl_req_type w;
      w.value = v;
      w.frame_last = fl;
      pending_words.push_back(w);
   endtask

   // One well-formed entry with random content.
   task automatic push_entry(int nc, bit want_keep, bit ends_frame);
      logic [31:0] obj;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(3))
            0: push_word($urandom_range(65536), 1'b0);
            1: push_word($urandom, 1'b0);
            default: push_word(32'($signed($urandom_range(200000)) - 100000), 1'b0);
         endcase
      end
      if (want_keep)
         obj = 32'(thr_q) + 1 + ($urandom_range(3) == 0 ? $urandom_range(32'h7FFE0000)
                                                        : $urandom_range(65536));
      else
         obj = ($urandom_range(1)) ? 32'($urandom_range(thr_q)) : ($urandom | 32'h8000_0000);
      push_word(obj, 1'b0);
      for (int c = 0; c < nc; c++)
         push_word(($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(131072)),
                   ends_frame && c == nc - 1);
   endtask

   initial begin
      int phase;
      logic [14:0] dims [4];
      int nc;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 27;
      thr_q = 17'd16384;
      img_w_q = 15'd416;
      img_h_q = 15'd416;
      net_w_q = 15'd416;
      net_h_q = 15'd416;
      rel_q = 1'b1;
      classes_q = 8'd80;
      refit_sizes();
      word_pos = 0;
      box_kept = 1'b0;
      kept_count = 0;
      obj_hold = '0;
      for (int i = 0; i < 4; i++) coord_hold[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: two classes, coordinate and score extremes, objectness at
      // and around the threshold, frame end part way through an entry.
      write_reg(CSR_NUM_CLASSES, 8'd2);
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h0, 1'b0);
      push_word(32'h0, 1'b0);
      push_word(32'h0, 1'b0);
      push_word(32'h0, 1'b0);
      push_word(32'd16384, 1'b0);
      push_word(32'd65536, 1'b0);
      push_word(32'd1, 1'b1);
      push_word(32'd100, 1'b0);
      push_word(32'd200, 1'b0);
      push_word(32'd300, 1'b0);
      push_word(32'd400, 1'b0);
      push_word(32'd16385, 1'b1);
      // Leave an entry open so the class count changes under it.
      push_entry(2, 1'b1, 1'b0);
      push_word(32'd5, 1'b0);
      push_word(32'd6, 1'b0);
      push_word(32'd7, 1'b0);
      push_word(32'd8, 1'b0);
      push_word(32'h10000, 1'b0);
      push_word(32'h10000, 1'b0);
      settle();
      write_reg(CSR_NUM_CLASSES, 8'd1);
      push_word(32'h20000, 1'b0);
      push_word(32'h30000, 1'b1);
      settle();

      // Zero sizes act as one, and a fitted height that rounds to zero.
      write_all(17'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 8'd1);
      push_entry(1, 1'b1, 1'b1);
      settle();
      write_all(17'd65536, 15'd16384, 15'd1, 15'd1, 15'd16384, 1'b0, 8'd1);
      push_entry(1, 1'b1, 1'b0);
      push_entry(1, 1'b0, 1'b1);
      settle();

      // Widest entries once.
      write_all(17'd16384, 15'd640, 15'd480, 15'd416, 15'd416, 1'b0, 8'd255);
      push_entry(255, 1'b1, 1'b1);
      settle();

      phase = 0;
      while (words_sent < 850) begin
         idle_pct = (phase == 2) ? 0 : 27;
         for (int i = 0; i < 4; i++)
            case ($urandom_range(4))
               0: dims[i] = 15'($urandom_range(1));
               1: dims[i] = 15'd16384;
               default: dims[i] = 15'($urandom_range(1, 2048));
            endcase
         nc = ($urandom_range(4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         case ($urandom_range(3))
            0: write_all(17'd0, dims[0], dims[1], dims[2], dims[3], 1'($urandom), 8'(nc));
            1: write_all(17'd65536, dims[0], dims[1], dims[2], dims[3], 1'($urandom),
                         8'(nc));
            default: write_all(17'($urandom_range(65536)), dims[0], dims[1], dims[2], dims[3],
                               1'($urandom), 8'(nc));
         endcase
         for (int e = 0; e < 14; e++) begin
            if ($urandom_range(9) == 0) begin
               // Noise: stray words, sometimes cutting a frame short.
               repeat ($urandom_range(1, 6)) push_word($urandom, ($urandom_range(5) == 0));
            end else begin
               push_entry(nc, $urandom_range(99) < 65, $urandom_range(5) == 0);
            end
         end
         push_word($urandom, 1'b1);
         settle();
         phase++;
      end
      idle_pct = 27;

      $display("covered %0d results (%0d boxes) from %0d words over %0d random phases,",
               results_seen, boxes_seen, words_sent, phase);
      $display("with register extremes, the widest entry and a long output hold-off");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ddl_pkg.sv
sv/ddl_div.sv
sv/ddl_fit.sv
sv/ddl_front.sv
sv/ddl_back.sv
sv/detection_decode_letterbox_top.sv
tb/detection_decode_letterbox_top_test.sv
